### rtl/stack_vm_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// Stack VM execute unit assertion macros
// Concurrent assertion wrappers used by the execute unit top-level RTL.
// ----------------------------------------------------------------------------
`ifndef STACK_VM_EXECUTE_UNIT_MACROS_SVH
`define STACK_VM_EXECUTE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked out of reset.
`define SVM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication, checked out of reset.
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define SVM_ASSERT(lbl, clk, rst_n, prop, msg)
`define SVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/svm_pkg.sv
// ----------------------------------------------------------------------------
// Stack VM package
// Opcodes, status codes, fixed widths and shared structs of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package svm_pkg;

    localparam int WORD_W     = 32;
    localparam int CMD_W      = 4;
    localparam int TGT_W      = 8;
    localparam int PC_W       = 9;
    localparam int LEN_W      = 9;
    localparam int ST_W       = 3;
    localparam int PROG_DEPTH = 256;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

    typedef enum logic [CMD_W-1:0] {
        CMD_NOP     = 4'd0,
        CMD_EXIT    = 4'd1,
        CMD_PUSH    = 4'd2,
        CMD_POP     = 4'd3,
        CMD_PRINT   = 4'd4,
        CMD_ADD     = 4'd5,
        CMD_SUB     = 4'd6,
        CMD_MUL     = 4'd7,
        CMD_LOAD    = 4'd8,
        CMD_SET     = 4'd9,
        CMD_STORE   = 4'd10,
        CMD_JMP     = 4'd11,
        CMD_SETJMP  = 4'd12,
        CMD_LOOP    = 4'd13,
        CMD_JMPLOOP = 4'd14
    } t_cmd;

    typedef enum logic [ST_W-1:0] {
        ST_RUN     = 3'd0,
        ST_EXIT    = 3'd1,
        ST_END     = 3'd2,
        ST_OVER    = 3'd3,
        ST_UNDER   = 3'd4,
        ST_BADADDR = 3'd5
    } t_status;

    // Architectural scalar state, passed between the control and execute logic.
    typedef struct packed {
        logic [WORD_W-1:0] jump_ref;
        logic [WORD_W-1:0] loop_count;
        logic [PC_W-1:0]   pc;
        t_status           status;
    } t_arch;

    // Execute-stage side effects other than the stack pointer and write address.
    typedef struct packed {
        logic              we;
        logic [WORD_W-1:0] wdata;
        logic              print_valid;
        logic [WORD_W-1:0] print_value;
    } t_exec_fx;

endpackage

### rtl/stack_vm_execute_unit.sv
// ----------------------------------------------------------------------------
// Stack VM execute unit
// Executes one stack machine instruction per input transaction and returns
// the next instruction index, print data and the sticky run status.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_cmd, i_operand, i_target
//   out      output     o_out_valid / i_out_stall o_next_pc, o_print_valid,
//                                                 o_print_value, o_status
//   cfg      input      i_cfg_valid / o_cfg_ready i_cfg_data (program length)
//
// One instruction per cycle while the output is not stalled. The stack RAM
// is read on accept; the execute stage then executes and writes back.
// A write landing on the same entry as a concurrent read is forwarded.
// After reset a clearing pass zeroes every stack entry, with input held
// in stall; configuration writes are taken throughout.
// A stalled output register holds the execute stage, which stalls the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "stack_vm_execute_unit_macros.svh"

module stack_vm_execute_unit import svm_pkg::*; #(
    parameter int STACK_DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [WORD_W-1:0] i_operand,
    input  logic [TGT_W-1:0]         i_target,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [PC_W-1:0]          o_next_pc,
    output logic                     o_print_valid,
    output logic signed [WORD_W-1:0] o_print_value,
    output logic [ST_W-1:0]          o_status,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LEN_W-1:0]         i_cfg_data
);

    localparam int SP_W = $clog2(STACK_DEPTH);

    // Control state
    logic              r_clr_active;
    logic [SP_W-1:0]   r_clr_addr;
    logic              r_ex_valid;
    logic              n_ex_valid;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [LEN_W-1:0]  r_len;
    logic [SP_W-1:0]   r_top;
    t_arch             r_arch;

    // Execute-stage payload
    logic [CMD_W-1:0]  r_ex_cmd;
    logic [WORD_W-1:0] r_ex_operand;
    logic [TGT_W-1:0]  r_ex_target;
    logic              r_fwd_a;
    logic              r_fwd_b;
    logic [WORD_W-1:0] r_fwd_data;

    // Output register payload
    logic [PC_W-1:0]   r_out_pc;
    logic              r_out_pv;
    logic [WORD_W-1:0] r_out_pval;
    logic [ST_W-1:0]   r_out_status;

    logic              ex_go;
    logic              in_acc;
    logic [SP_W-1:0]   top_now;
    logic [SP_W-1:0]   raddr_a;
    logic [SP_W-1:0]   raddr_b;
    logic              mem_we;
    logic [SP_W-1:0]   mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] rd_a;
    logic [WORD_W-1:0] rd_b;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    logic [SP_W-1:0]   x_top;
    t_arch             x_arch;
    logic [SP_W-1:0]   x_waddr;
    t_exec_fx          x_fx;

    assign ex_go       = r_ex_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_clr_active || (r_ex_valid && !ex_go);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign word_a = r_fwd_a ? r_fwd_data : rd_a;
    assign word_b = r_fwd_b ? r_fwd_data : rd_b;

    // Read addresses see the stack pointer after the instruction now executing.
    assign top_now = ex_go ? x_top : r_top;
    assign raddr_a = (i_cmd == CMD_LOAD) ? i_operand[SP_W-1:0] : top_now;
    assign raddr_b = top_now - SP_W'(1);

    assign mem_we    = r_clr_active || (ex_go && x_fx.we);
    assign mem_waddr = r_clr_active ? r_clr_addr : x_waddr;
    assign mem_wdata = r_clr_active ? '0 : x_fx.wdata;

    svm_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (SP_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (in_acc),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    svm_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .SP_W        (SP_W)
    ) u_exec (
        .i_cmd     (r_ex_cmd),
        .i_operand (r_ex_operand),
        .i_target  (r_ex_target),
        .i_len     (r_len),
        .i_top     (r_top),
        .i_arch    (r_arch),
        .i_word_a  (word_a),
        .i_word_b  (word_b),
        .o_top     (x_top),
        .o_arch    (x_arch),
        .o_waddr   (x_waddr),
        .o_fx      (x_fx)
    );

    always_comb begin
        n_ex_valid = r_ex_valid;
        if (in_acc) begin
            n_ex_valid = 1'b1;
        end else if (ex_go) begin
            n_ex_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (ex_go) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_ex_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_len        <= LEN_RESET;
            r_top        <= '0;
            r_arch       <= '{jump_ref: '0, loop_count: '0, pc: '0, status: ST_RUN};
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + SP_W'(1);
                if (r_clr_addr == SP_W'(STACK_DEPTH - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_ex_valid  <= n_ex_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_len <= i_cfg_data;
            end
            if (ex_go) begin
                r_top  <= x_top;
                r_arch <= x_arch;
            end
        end
    end

    // Capture the transaction and note writes the RAM read will miss.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ex_cmd     <= i_cmd;
            r_ex_operand <= i_operand;
            r_ex_target  <= i_target;
            r_fwd_a      <= mem_we && (mem_waddr == raddr_a);
            r_fwd_b      <= mem_we && (mem_waddr == raddr_b);
            r_fwd_data   <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_go) begin
            r_out_pc     <= x_arch.pc;
            r_out_pv     <= x_fx.print_valid;
            r_out_pval   <= x_fx.print_value;
            r_out_status <= x_arch.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_out_pc;
    assign o_print_valid = r_out_pv;
    assign o_print_value = r_out_pval;
    assign o_status      = r_out_status;

    `SVM_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_arch.status != ST_RUN,
        r_arch.status == $past(r_arch.status) && r_arch.pc == $past(r_arch.pc),
        "halted state changed")

    `SVM_ASSERT(a_clear_empty, i_clk, i_rst_n,
        (r_clr_active |-> !r_ex_valid && !r_out_valid), "item in flight during clear")

    `SVM_ASSERT_NEXT(a_ex_hold, i_clk, i_rst_n,
        r_ex_valid && r_out_valid && i_out_stall, r_ex_valid,
        "execute stage dropped while output blocked")

    `SVM_ASSERT(a_print_running, i_clk, i_rst_n,
        (r_out_valid && r_out_pv |-> r_out_status == ST_RUN || r_out_status == ST_END),
        "print reported with error status")

endmodule

### rtl/svm_stack_ram.sv
// ----------------------------------------------------------------------------
// Stack word memory
// Synchronous RAM, one write port and two read ports with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svm_stack_ram import svm_pkg::*; #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr_a,
    input  logic [AW-1:0]     i_raddr_b,
    output logic [WORD_W-1:0] o_rdata_a,
    output logic [WORD_W-1:0] o_rdata_b
);

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_a;
    logic [WORD_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read-before-write: a read at the write address returns the old word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_a <= r_mem[i_raddr_a];
            r_rd_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

### rtl/svm_exec.sv
// ----------------------------------------------------------------------------
// Stack VM instruction execute
// Decodes one instruction against the current state and stack words and
// produces the next state, the stack write and the print result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module svm_exec import svm_pkg::*; #(
    parameter int STACK_DEPTH = 32768,
    parameter int SP_W        = 15
) (
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [WORD_W-1:0] i_operand,
    input  logic [TGT_W-1:0]  i_target,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [SP_W-1:0]   i_top,
    input  t_arch             i_arch,
    input  logic [WORD_W-1:0] i_word_a,
    input  logic [WORD_W-1:0] i_word_b,
    output logic [SP_W-1:0]   o_top,
    output t_arch             o_arch,
    output logic [SP_W-1:0]   o_waddr,
    output t_exec_fx          o_fx
);

    logic [SP_W:0]       top_inc;
    logic                can_push;
    logic                addr_ok;
    logic [WORD_W-1:0]   prod;
    logic [WORD_W-1:0]   arith;
    logic [PC_W-1:0]     next_pc;
    logic [PC_W-1:0]     len_eff;

    assign top_inc  = (SP_W+1)'(i_top) + (SP_W+1)'(1);
    assign can_push = top_inc < (SP_W+1)'(STACK_DEPTH);
    assign addr_ok  = !i_operand[WORD_W-1] && (i_operand < WORD_W'(STACK_DEPTH));
    assign prod     = i_word_a * i_word_b;
    assign len_eff  = (i_len > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH) : i_len;

    always_comb begin
        case (i_cmd)
            CMD_ADD: arith = i_word_a + i_word_b;
            CMD_SUB: arith = i_word_a - i_word_b;
            default: arith = prod;
        endcase
    end

    always_comb begin
        o_arch  = i_arch;
        o_top   = i_top;
        o_waddr = top_inc[SP_W-1:0];
        o_fx    = '0;
        next_pc = i_arch.pc + PC_W'(1);

        if (o_arch.status == ST_RUN && i_arch.pc >= len_eff) begin
            o_arch.status = ST_END;
        end

        if (o_arch.status == ST_RUN) begin
            case (i_cmd)
                CMD_EXIT: begin
                    o_arch.status = ST_EXIT;
                end
                CMD_PUSH: begin
                    if (can_push) begin
                        o_top           = top_inc[SP_W-1:0];
                        o_fx.we         = 1'b1;
                        o_fx.wdata      = i_operand;
                        o_arch.jump_ref = i_operand;
                    end else begin
                        o_arch.status = ST_OVER;
                    end
                end
                CMD_POP: begin
                    if (i_top == '0) begin
                        o_arch.status = ST_UNDER;
                    end else begin
                        o_top = i_top - SP_W'(1);
                    end
                end
                CMD_PRINT: begin
                    o_fx.print_valid = 1'b1;
                    o_fx.print_value = i_word_a;
                end
                CMD_ADD, CMD_SUB, CMD_MUL: begin
                    if (i_top == '0) begin
                        o_arch.status = ST_UNDER;
                    end else if (!can_push) begin
                        o_arch.status = ST_OVER;
                    end else begin
                        o_top           = top_inc[SP_W-1:0];
                        o_fx.we         = 1'b1;
                        o_fx.wdata      = arith;
                        o_arch.jump_ref = arith;
                    end
                end
                CMD_LOAD: begin
                    if (!addr_ok) begin
                        o_arch.status = ST_BADADDR;
                    end else if (!can_push) begin
                        o_arch.status = ST_OVER;
                    end else begin
                        o_top           = top_inc[SP_W-1:0];
                        o_fx.we         = 1'b1;
                        o_fx.wdata      = i_word_a;
                        o_arch.jump_ref = i_word_a;
                    end
                end
                CMD_SET: begin
                    if (!addr_ok) begin
                        o_arch.status = ST_BADADDR;
                    end else begin
                        o_top = i_operand[SP_W-1:0];
                    end
                end
                CMD_STORE: begin
                    if (!addr_ok) begin
                        o_arch.status = ST_BADADDR;
                    end else begin
                        o_fx.we    = 1'b1;
                        o_waddr    = i_operand[SP_W-1:0];
                        o_fx.wdata = i_word_a;
                    end
                end
                CMD_JMP: begin
                    if ($signed(i_operand) >= $signed(i_arch.jump_ref)) begin
                        next_pc = PC_W'(i_target) + PC_W'(1);
                    end
                end
                CMD_LOOP: begin
                    if (i_operand == '0) begin
                        o_arch.loop_count = '0;
                    end else begin
                        o_arch.loop_count = i_arch.loop_count + WORD_W'(1);
                    end
                end
                CMD_JMPLOOP: begin
                    if ($signed(i_operand) >= $signed(i_arch.loop_count)) begin
                        next_pc = PC_W'(i_target) + PC_W'(1);
                    end
                end
                default: begin
                end
            endcase

            // Advance only when the instruction left the machine running.
            if (o_arch.status == ST_RUN) begin
                o_arch.pc = next_pc;
                if (next_pc >= len_eff) begin
                    o_arch.status = ST_END;
                end
            end
        end
    end

endmodule
